FILE: hw/rtl/sle_pkg.sv
// shared command, status and cell control definitions for the shifting list engine
package sle_pkg;

    localparam logic [2:0] CMD_APPEND     = 3'd0;
    localparam logic [2:0] CMD_INSERT     = 3'd1;
    localparam logic [2:0] CMD_REMOVE_VAL = 3'd2;
    localparam logic [2:0] CMD_REMOVE_AT  = 3'd3;
    localparam logic [2:0] CMD_READ       = 3'd4;
    localparam logic [2:0] CMD_NEXT       = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_MISS  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    localparam logic [2:0] CELL_HOLD       = 3'd0;
    localparam logic [2:0] CELL_APPEND     = 3'd1;
    localparam logic [2:0] CELL_INSERT     = 3'd2;
    localparam logic [2:0] CELL_DROP_AT    = 3'd3;
    localparam logic [2:0] CELL_DROP_MATCH = 3'd4;

    localparam int IN_BITS  = 40;
    localparam int OUT_BITS = 40;

    typedef struct packed {
        logic       en;
        logic [2:0] op;
    } cell_ctrl_t;

endpackage

FILE: hw/rtl/sle_cell.sv
// one list cell: holds an entry, compares it with the key and shifts with its neighbors
module sle_cell #(
    parameter int IDX       = 0,
    parameter int WORD_BITS = 32,
    parameter int CNT_W     = 5
) (
    input  logic                   clk,
    input  sle_pkg::cell_ctrl_t    ctrl,
    input  logic [CNT_W-1:0]       fill_count,
    input  logic [3:0]             target_pos,
    input  logic [WORD_BITS-1:0]   key,
    input  logic [WORD_BITS-1:0]   new_word,
    input  logic [WORD_BITS-1:0]   lower_word,
    input  logic [WORD_BITS-1:0]   upper_word,
    input  logic                   seen_in,
    output logic [WORD_BITS-1:0]   word,
    output logic                   seen_out
);
    import sle_pkg::*;

    localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

    logic [WORD_BITS-1:0] word_reg;
    logic [WORD_BITS-1:0] word_next;
    logic                 match_reg;
    logic                 match_next;
    logic                 live;
    logic                 at_or_above;
    logic                 at_tail;

    assign live        = CNT_W'(IDX) < fill_count;
    assign at_tail     = CNT_W'(IDX) == fill_count;
    assign at_or_above = CMP_W'(IDX) >= CMP_W'(target_pos);
    assign match_next  = live && (word_reg == key);
    assign seen_out    = seen_in | match_reg;
    assign word        = word_reg;

    always_comb
    begin
        word_next = word_reg;
        if (ctrl.en)
        begin
            case (ctrl.op)
                CELL_APPEND:     word_next = at_tail ? new_word : word_reg;
                CELL_INSERT:     word_next = lower_word;
                CELL_DROP_AT:    word_next = at_or_above ? upper_word : word_reg;
                CELL_DROP_MATCH: word_next = seen_out ? upper_word : word_reg;
                default:         word_next = word_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        match_reg <= match_next;
    end

endmodule

FILE: hw/rtl/shifting_list_engine_unit.sv
// top level of the shifting list engine: command sequencer, count, cursor and cell chain
// An ordered list of up to DEPTH words kept in a row of cells, one entry per cell.
// Commands append, insert at the head, remove the first matching value, remove at an
// index, read at an index, or read through a wrapping cursor; each command returns one
// result with the read word, a status and the entry count after the command. One command
// is handled at a time: the command is captured at its transfer, then every cell registers
// its compare against the key, then the chain shifts and count and cursor are updated, and
// the result is offered; the next command is taken the cycle after the result transfer.
// The list comes out of reset empty and needs no clearing time.
module shifting_list_engine_unit #(
    parameter int DEPTH     = 16,
    parameter int WORD_BITS = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // cmd[2:0], item_value[34:3], position[38:35], zero[39]
    input  logic [sle_pkg::IN_BITS-1:0]   s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // read_value[31:0], status[33:32], item_count[38:34], zero[39]
    output logic [sle_pkg::OUT_BITS-1:0]  m_axis_tdata
);
    import sle_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CUR_W = $clog2(DEPTH);
    localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_MATCH = 2'd1;
    localparam logic [1:0] S_EXEC  = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [2:0]           cmd_reg;
    logic [WORD_BITS-1:0] key_reg;
    logic [3:0]           pos_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic [CUR_W-1:0]     cursor_reg;
    logic [CUR_W-1:0]     cursor_next;
    logic [31:0]          rd_value_reg;
    logic [31:0]          rd_value_next;
    logic [1:0]           status_reg;
    logic [1:0]           status_next;
    logic [4:0]           out_count_reg;

    logic                 in_transfer;
    logic                 out_transfer;
    logic                 full;
    logic                 empty;
    logic                 pos_ok;
    logic                 found;
    logic [CUR_W-1:0]     cur_start;
    logic [CUR_W-1:0]     rd_addr;
    logic [WORD_BITS-1:0] rd_word;
    logic                 exec_write;
    logic [2:0]           exec_op;
    cell_ctrl_t           ctrl;

    logic [WORD_BITS-1:0] cell_word [DEPTH];
    logic                 seen      [DEPTH+1];

    assign in_transfer   = s_axis_tvalid && s_axis_tready;
    assign out_transfer  = m_axis_tvalid && m_axis_tready;
    assign s_axis_tready = state_reg == S_IDLE;
    assign m_axis_tvalid = state_reg == S_OUT;
    assign m_axis_tdata  = {1'b0, out_count_reg, status_reg, rd_value_reg};

    // cell chain
    assign seen[0] = 1'b0;
    assign found   = seen[DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [WORD_BITS-1:0] lower;
        logic [WORD_BITS-1:0] upper;

        if (i == 0)
        begin : g_first
            assign lower = key_reg;
        end
        else
        begin : g_mid_lo
            assign lower = cell_word[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign upper = cell_word[i];
        end
        else
        begin : g_mid_hi
            assign upper = cell_word[i+1];
        end

        sle_cell #(
            .IDX       (i),
            .WORD_BITS (WORD_BITS),
            .CNT_W     (CNT_W)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .fill_count (count_reg),
            .target_pos (pos_reg),
            .key        (key_reg),
            .new_word   (key_reg),
            .lower_word (lower),
            .upper_word (upper),
            .seen_in    (seen[i]),
            .word       (cell_word[i]),
            .seen_out   (seen[i+1])
        );
    end

    // command decode
    assign full      = count_reg == CNT_W'(DEPTH);
    assign empty     = count_reg == '0;
    assign pos_ok    = CMP_W'(pos_reg) < CMP_W'(count_reg);
    assign cur_start = (CNT_W'(cursor_reg) >= count_reg) ? '0 : cursor_reg;
    assign rd_addr   = (cmd_reg == CMD_NEXT) ? cur_start : CUR_W'(pos_reg);
    assign rd_word   = cell_word[rd_addr];

    always_comb
    begin
        exec_write    = 1'b0;
        exec_op       = CELL_HOLD;
        status_next   = ST_OK;
        rd_value_next = '0;
        count_next    = count_reg;
        cursor_next   = cursor_reg;
        unique case (cmd_reg)
            CMD_APPEND, CMD_INSERT:
            begin
                if (full)
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    exec_write = 1'b1;
                    exec_op    = (cmd_reg == CMD_APPEND) ? CELL_APPEND : CELL_INSERT;
                    count_next = count_reg + 1'b1;
                end
            end
            CMD_REMOVE_VAL:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (!found)
                begin
                    status_next = ST_MISS;
                end
                else
                begin
                    exec_write = 1'b1;
                    exec_op    = CELL_DROP_MATCH;
                    count_next = count_reg - 1'b1;
                end
            end
            CMD_REMOVE_AT:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (!pos_ok)
                begin
                    status_next = ST_MISS;
                end
                else
                begin
                    exec_write = 1'b1;
                    exec_op    = CELL_DROP_AT;
                    count_next = count_reg - 1'b1;
                end
            end
            CMD_READ:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (!pos_ok)
                begin
                    status_next = ST_MISS;
                end
                else
                begin
                    rd_value_next = 32'(rd_word);
                end
            end
            CMD_NEXT:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else
                begin
                    rd_value_next = 32'(rd_word);
                    cursor_next   = (cur_start == CUR_W'(DEPTH - 1)) ? '0
                                                                     : cur_start + 1'b1;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    assign ctrl.en = (state_reg == S_EXEC) && exec_write;
    assign ctrl.op = exec_op;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_transfer) state_next = S_MATCH;
            S_MATCH: state_next = S_EXEC;
            S_EXEC:  state_next = S_OUT;
            S_OUT:   if (out_transfer) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            cursor_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_EXEC)
            begin
                count_reg  <= count_next;
                cursor_reg <= cursor_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_transfer)
        begin
            cmd_reg <= s_axis_tdata[2:0];
            key_reg <= WORD_BITS'(s_axis_tdata[34:3]);
            pos_reg <= s_axis_tdata[38:35];
        end
        if (state_reg == S_EXEC)
        begin
            rd_value_reg  <= rd_value_next;
            status_reg    <= status_next;
            out_count_reg <= 5'(count_next);
        end
    end

endmodule
